FILE: hw/rtl/upq_pkg.sv
// Shared types and codes for the unsorted array priority queue.
package upq_pkg;

    localparam logic [1:0] OP_INSERT  = 2'd0;
    localparam logic [1:0] OP_DELETE  = 2'd1;
    localparam logic [1:0] OP_PEEK    = 2'd2;
    localparam logic [1:0] OP_EXTRACT = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic       capture;
        logic       ins_write;
        logic       scan_clear;
        logic       scan_en;
        logic       max_mode;
        logic       shift_init;
        logic       shift_en;
        logic       remove;
        logic       reply;
        logic       reply_data;
        logic [1:0] status;
    } upq_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic scan_last;
        logic hit;
        logic shift_none;
        logic shift_last;
    } upq_stat_t;

endpackage

FILE: hw/rtl/unsorted_array_priority_queue.sv
// Top level of the unsorted array priority queue.
// Insert and any failing command on an empty or full queue go from idle straight to the reply state.
// Peek makes one scan pass over the entries held, and delete or extract may add a shift pass after it;
// the entry memory is read one word a cycle in both the scan and the shift pass.
// One command is worked at a time; busy stays high until the result strobe.
// Reset empties the queue; entry contents are left as they are.
module unsorted_array_priority_queue
    import upq_pkg::*;
#(
    parameter int DEPTH = 128
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         op,
    input  logic signed [31:0] item_value,
    input  logic signed [31:0] item_priority,
    output logic               done,
    output logic [1:0]         status,
    output logic signed [31:0] out_value,
    output logic signed [31:0] out_priority,
    output logic [7:0]         occupancy
);

    upq_cmd_t  cmd;
    upq_stat_t stat;

    upq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (op),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    upq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .item_value    (item_value),
        .item_priority (item_priority),
        .done          (done),
        .status        (status),
        .out_value     (out_value),
        .out_priority  (out_priority),
        .occupancy     (occupancy)
    );

endmodule

FILE: hw/rtl/upq_dp.sv
// Datapath: entry memory, scan pipeline, match and maximum tracking, result registers.
module upq_dp
    import upq_pkg::*;
#(
    parameter int DEPTH = 128
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  upq_cmd_t           cmd,
    output upq_stat_t          stat,
    input  logic signed [31:0] item_value,
    input  logic signed [31:0] item_priority,
    output logic               done,
    output logic [1:0]         status,
    output logic signed [31:0] out_value,
    output logic signed [31:0] out_priority,
    output logic [7:0]         occupancy
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int OW = CW + 8;

    logic [63:0]        mem [DEPTH];
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      rptr_reg;
    logic [AW-1:0]      ridx_reg;
    logic [AW-1:0]      hit_reg;
    logic               rvld_reg;
    logic               found_reg;
    logic [63:0]        rdata_reg;
    logic signed [31:0] key_reg;
    logic signed [31:0] best_val_reg;
    logic signed [31:0] best_pri_reg;
    logic               done_reg;
    logic [1:0]         status_reg;
    logic signed [31:0] out_value_reg;
    logic signed [31:0] out_priority_reg;
    logic [7:0]         occupancy_reg;

    logic [CW-1:0]      cnt_m1;
    logic [AW-1:0]      last_idx;
    logic signed [31:0] rd_val;
    logic signed [31:0] rd_pri;
    logic               issue;
    logic               take_max;
    logic               take_hit;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [63:0]        wr_data;
    logic [OW-1:0]      occ_ext;

    assign cnt_m1   = count_reg - CW'(1);
    assign last_idx = cnt_m1[AW-1:0];
    assign rd_val   = rdata_reg[63:32];
    assign rd_pri   = rdata_reg[31:0];
    assign issue    = (cmd.scan_en || cmd.shift_en) && (rptr_reg < count_reg);
    assign occ_ext  = OW'(count_reg);

    // The first word seen always seeds the maximum; later ones must be strictly greater.
    assign take_max = cmd.scan_en && cmd.max_mode && rvld_reg
                      && ((ridx_reg == '0) || (rd_pri > best_pri_reg));
    assign take_hit = cmd.scan_en && !cmd.max_mode && rvld_reg && !found_reg
                      && (rd_val == key_reg);

    assign stat.full       = (count_reg == CW'(DEPTH));
    assign stat.empty      = (count_reg == '0);
    assign stat.scan_last  = rvld_reg && (ridx_reg == last_idx);
    assign stat.hit        = found_reg || take_hit;
    assign stat.shift_none = (hit_reg == last_idx);
    assign stat.shift_last = rvld_reg && (ridx_reg == last_idx);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = count_reg[AW-1:0];
        wr_data = {item_value, item_priority};
        if (cmd.ins_write)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.shift_en && rvld_reg)
        begin
            // Each word read during the shift moves down by one slot.
            wr_en   = 1'b1;
            wr_addr = ridx_reg - AW'(1);
            wr_data = rdata_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (issue)
        begin
            rdata_reg <= mem[rptr_reg[AW-1:0]];
            ridx_reg  <= rptr_reg[AW-1:0];
        end
        if (cmd.capture)
        begin
            key_reg <= item_value;
        end
        if (take_max)
        begin
            best_val_reg <= rd_val;
            best_pri_reg <= rd_pri;
            hit_reg      <= ridx_reg;
        end
        if (take_hit)
        begin
            hit_reg <= ridx_reg;
        end
        if (cmd.reply)
        begin
            status_reg       <= cmd.status;
            out_value_reg    <= cmd.reply_data ? best_val_reg : 32'sd0;
            out_priority_reg <= cmd.reply_data ? best_pri_reg : 32'sd0;
            occupancy_reg    <= occ_ext[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            rptr_reg  <= '0;
            rvld_reg  <= 1'b0;
            found_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            rvld_reg <= issue;
            done_reg <= cmd.reply;
            if (cmd.scan_clear)
            begin
                rptr_reg  <= '0;
                found_reg <= 1'b0;
            end
            else if (cmd.shift_init)
            begin
                rptr_reg <= CW'(hit_reg) + CW'(1);
            end
            else if (issue)
            begin
                rptr_reg <= rptr_reg + CW'(1);
            end
            if (take_hit)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.ins_write)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (cmd.remove)
            begin
                count_reg <= cnt_m1;
            end
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign out_value    = out_value_reg;
    assign out_priority = out_priority_reg;
    assign occupancy    = occupancy_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rvld_reg |-> (CW'(ridx_reg) < count_reg))
        else $error("read word beyond held entries");

    a_remove_dec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.remove |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("remove did not decrement count");

    a_insert_inc: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins_write |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not increment count");

endmodule

FILE: hw/rtl/upq_ctrl.sv
// Controller state machine sequencing insert, scan, shift and reply.
module upq_ctrl
    import upq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic [1:0] op,
    output logic      busy,
    output upq_cmd_t  cmd,
    input  upq_stat_t stat
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_SHINIT = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_REPLY  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [1:0] op_reg, op_next;
    logic [1:0] st_reg, st_next;
    logic       data_reg, data_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        op_next    = op_reg;
        st_next    = st_reg;
        data_next  = data_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next     = op;
                    data_next   = 1'b0;
                    cmd.capture = 1'b1;
                    state_next  = S_REPLY;
                    case (op)
                        OP_INSERT:
                        begin
                            if (stat.full)
                            begin
                                st_next = ST_FULL;
                            end
                            else
                            begin
                                cmd.ins_write = 1'b1;
                                st_next       = ST_OK;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (stat.empty)
                            begin
                                st_next = ST_NOT_FOUND;
                            end
                            else
                            begin
                                cmd.scan_clear = 1'b1;
                                state_next     = S_SCAN;
                            end
                        end
                        default:
                        begin
                            if (stat.empty)
                            begin
                                st_next = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.scan_clear = 1'b1;
                                state_next     = S_SCAN;
                            end
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                cmd.scan_en  = 1'b1;
                cmd.max_mode = (op_reg != OP_DELETE);
                if (stat.scan_last)
                begin
                    if (op_reg == OP_DELETE)
                    begin
                        if (stat.hit)
                        begin
                            st_next    = ST_OK;
                            state_next = S_SHINIT;
                        end
                        else
                        begin
                            st_next    = ST_NOT_FOUND;
                            state_next = S_REPLY;
                        end
                    end
                    else
                    begin
                        st_next    = ST_OK;
                        data_next  = 1'b1;
                        state_next = (op_reg == OP_EXTRACT) ? S_SHINIT : S_REPLY;
                    end
                end
            end
            S_SHINIT:
            begin
                cmd.shift_init = 1'b1;
                if (stat.shift_none)
                begin
                    // The removed entry was the last one, so nothing moves.
                    cmd.remove = 1'b1;
                    state_next = S_REPLY;
                end
                else
                begin
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                cmd.shift_en = 1'b1;
                if (stat.shift_last)
                begin
                    cmd.remove = 1'b1;
                    state_next = S_REPLY;
                end
            end
            S_REPLY:
            begin
                cmd.reply      = 1'b1;
                cmd.reply_data = data_reg;
                cmd.status     = st_reg;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_INSERT;
            st_reg    <= ST_OK;
            data_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            st_reg    <= st_next;
            data_reg  <= data_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    a_reply_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.reply |=> !cmd.reply)
        else $error("reply issued on two cycles in a row");

    a_data_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.reply && cmd.reply_data) |-> (cmd.status == ST_OK))
        else $error("entry data returned with a failing status");

    a_no_work_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> !(cmd.scan_en || cmd.shift_en || cmd.remove))
        else $error("datapath work while idle");

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench for the unsorted array priority queue: directed and random commands against a predictor.
module tb_top;
    import upq_pkg::*;

    localparam int QUEUE_DEPTH = 128;
    localparam longint CYCLE_LIMIT = 1500000;
    localparam int MAX_PRINTED = 30;
    localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] WORD_MAX = 32'sh7FFF_FFFF;

    typedef struct {
        logic [1:0]         status;
        logic signed [31:0] value;
        logic signed [31:0] prio;
        logic [7:0]         occupancy;
    } reply_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         op;
    logic signed [31:0] item_value;
    logic signed [31:0] item_priority;
    logic               done;
    logic [1:0]         status;
    logic signed [31:0] out_value;
    logic signed [31:0] out_priority;
    logic [7:0]         occupancy;

    logic signed [31:0] held_value[$];
    logic signed [31:0] held_prio[$];
    reply_t             pending_replies[$];
    int                 error_count = 0;
    longint             cycle_count = 0;
    int                 idle_pct = 0;

    unsorted_array_priority_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .item_value   (item_value),
        .item_priority(item_priority),
        .done         (done),
        .status       (status),
        .out_value    (out_value),
        .out_priority (out_priority),
        .occupancy    (occupancy)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Applies one command to the shadow queue and returns the word it should produce.
    function automatic reply_t compute_reply(logic [1:0] cmd, logic signed [31:0] v,
                                             logic signed [31:0] p);
        reply_t r;
        int     hit;
        int     best;
        r.status = ST_OK;
        r.value  = '0;
        r.prio   = '0;
        case (cmd)
            OP_INSERT:
            begin
                if (held_value.size() >= QUEUE_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    held_value.push_back(v);
                    held_prio.push_back(p);
                end
            end
            OP_DELETE:
            begin
                hit = -1;
                for (int i = 0; i < held_value.size(); i++)
                begin
                    if (held_value[i] == v)
                    begin
                        hit = i;
                        break;
                    end
                end
                if (hit < 0)
                    r.status = ST_NOT_FOUND;
                else
                begin
                    held_value.delete(hit);
                    held_prio.delete(hit);
                end
            end
            default:
            begin
                if (held_value.size() == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    // Strict compare keeps the lowest index on a tie.
                    best = 0;
                    for (int i = 1; i < held_prio.size(); i++)
                        if (held_prio[i] > held_prio[best])
                            best = i;
                    r.value = held_value[best];
                    r.prio  = held_prio[best];
                    if (cmd == OP_EXTRACT)
                    begin
                        held_value.delete(best);
                        held_prio.delete(best);
                    end
                end
            end
        endcase
        r.occupancy = 8'(held_value.size());
        return r;
    endfunction

    function automatic logic signed [31:0] random_word();
        case ($urandom_range(0, 3))
            0: return 32'($urandom_range(0, 7));
            1:
            begin
                case ($urandom_range(0, 3))
                    0: return WORD_MIN;
                    1: return WORD_MAX;
                    2: return -32'sd1;
                    default: return 32'sd0;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic report_error(string msg);
        if (error_count < MAX_PRINTED)
            $display("%0t: %s", $time, msg);
        error_count++;
    endtask

    // Drops start for a random stretch so the queue sits idle between some words.
    task automatic sender_gap();
        int n;
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            n = $urandom_range(1, 2 * held_value.size() + 8);
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_word(logic [1:0] cmd, logic signed [31:0] v, logic signed [31:0] p);
        start         <= 1'b1;
        op            <= cmd;
        item_value    <= v;
        item_priority <= p;
        do
            @(posedge clk);
        while (busy);
        pending_replies.push_back(compute_reply(cmd, v, p));
        sender_gap();
    endtask

    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n && done)
        begin
            if (pending_replies.size() == 0)
                report_error("result word with no command outstanding");
            else
            begin
                want = pending_replies.pop_front();
                if (status !== want.status)
                    report_error($sformatf("status got %0d expected %0d", status, want.status));
                if (out_value !== want.value)
                    report_error($sformatf("out_value got %h expected %h",
                                           out_value, want.value));
                if (out_priority !== want.prio)
                    report_error($sformatf("out_priority got %h expected %h",
                                           out_priority, want.prio));
                if (occupancy !== want.occupancy)
                    report_error($sformatf("occupancy got %0d expected %0d",
                                           occupancy, want.occupancy));
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_top: errors");
        $finish;
    end

    task automatic test_empty_queue();
        send_word(OP_PEEK, 32'sd0, 32'sd0);
        send_word(OP_EXTRACT, 32'sd0, 32'sd0);
        send_word(OP_DELETE, 32'sd0, 32'sd0);
    endtask

    task automatic test_extreme_fields();
        send_word(OP_INSERT, WORD_MIN, WORD_MAX);
        send_word(OP_INSERT, WORD_MAX, WORD_MIN);
        send_word(OP_INSERT, -32'sd1, -32'sd1);
        send_word(OP_INSERT, 32'sd0, 32'sd0);
        send_word(OP_INSERT, 32'sd7, WORD_MAX);
        send_word(OP_PEEK, 32'sd0, 32'sd0);
        send_word(OP_EXTRACT, 32'sd0, 32'sd0);
        send_word(OP_PEEK, 32'sd0, 32'sd0);
        send_word(OP_DELETE, -32'sd1, 32'sd0);
        send_word(OP_DELETE, 32'sd12345, 32'sd0);
    endtask

    // Equal values with different priorities: extract must take the maximum's own slot.
    task automatic test_duplicate_values();
        send_word(OP_INSERT, 32'sd5, 32'sd1);
        send_word(OP_INSERT, 32'sd5, WORD_MAX);
        send_word(OP_INSERT, 32'sd5, 32'sd9);
        send_word(OP_EXTRACT, 32'sd0, 32'sd0);
        send_word(OP_DELETE, 32'sd5, 32'sd0);
    endtask

    task automatic test_drain();
        while (held_value.size() > 0)
            send_word(OP_EXTRACT, 32'sd0, 32'sd0);
        send_word(OP_EXTRACT, 32'sd0, 32'sd0);
    endtask

    task automatic test_random_mix(int count, int insert_pct);
        int                 pick;
        logic signed [31:0] v;
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 99) < insert_pct)
                send_word(OP_INSERT, random_word(), random_word());
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 35)
                begin
                    if (held_value.size() > 0 && $urandom_range(0, 3) != 0)
                        v = held_value[$urandom_range(0, held_value.size() - 1)];
                    else
                        v = random_word();
                    send_word(OP_DELETE, v, random_word());
                end
                else if (pick < 50)
                    send_word(OP_PEEK, random_word(), random_word());
                else
                    send_word(OP_EXTRACT, random_word(), random_word());
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        start         = 1'b0;
        op            = OP_INSERT;
        item_value    = '0;
        item_priority = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_queue();
        test_extreme_fields();
        test_duplicate_values();
        test_drain();

        // Fill until full, then drain toward empty with the sender mostly idle, then run two mixed phases.
        idle_pct = 0;
        test_random_mix(200, 88);
        idle_pct = 82;
        test_random_mix(250, 10);
        idle_pct = 6;
        test_random_mix(150, 55);
        idle_pct = 0;
        test_random_mix(150, 45);

        start <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
